// ----- rtl/cdq_pkg.sv -----
// shared constants, types and helper functions of the subcode q generator
package cdq_pkg;

   // table geometry and disc timing
   localparam int unsigned MaxTracks        = 32;
   localparam int unsigned SlotWidth        = 5;
   localparam int unsigned LeadIn           = 150;
   localparam int unsigned FramesPerSecond  = 75;
   localparam int unsigned SecondsPerMinute = 60;

   // stream packing
   localparam int unsigned ReqDataWidth = 72;
   localparam int unsigned RspDataWidth = 88;

   // constant division by reciprocal multiplication, exact for 20 bit dividends by 75 and 14 bit dividends by 60
   localparam logic [19:0] Div75Mult   = 20'd894785;
   localparam int unsigned Div75Shift  = 26;
   localparam logic [18:0] Div60Mult   = 19'd279621;
   localparam int unsigned Div60Shift  = 24;
   localparam int unsigned QuotWidth   = 14;
   localparam int unsigned MinuteWidth = 8;

   // q frame bytes
   localparam logic [15:0] CrcPoly      = 16'h1021;
   localparam logic [7:0]  ControlData  = 8'h41;
   localparam logic [7:0]  ControlAudio = 8'h01;
   localparam logic [7:0]  IndexOne     = 8'h01;
   localparam logic [7:0]  PadByte      = 8'h00;

   typedef enum logic {
      CMD_LOAD  = 1'b0,
      CMD_QUERY = 1'b1
   } cmd_type;

   // crc-16/ccitt of one byte shifted through a zero register, msb first
   function automatic logic [15:0] crc_byte(input logic [7:0] idx);
      logic [15:0] c;
      c = {idx, 8'h00};
      for (int b = 0; b < 8; b++) begin
         c = c[15] ? ({c[14:0], 1'b0} ^ CrcPoly) : {c[14:0], 1'b0};
      end
      return c;
   endfunction

   // one byte step of the table driven crc
   function automatic logic [15:0] crc_next(input logic [15:0] crc, input logic [7:0] data);
      return {crc[7:0], 8'h00} ^ crc_byte(crc[15:8] ^ data);
   endfunction

   // packed bcd kept to 8 bits, tens by multiply with 205 and shift by 11
   function automatic logic [7:0] bcd8(input logic [7:0] v);
      logic [15:0] p;
      logic [4:0]  tens;
      logic [7:0]  ones;
      p    = 16'(v) * 16'd205;
      tens = p[15:11];
      ones = 8'(v - 8'(8'(tens) * 8'd10));
      return {tens[3:0], ones[3:0]};
   endfunction

endpackage

// ----- rtl/cd_subcode_q_generator.sv -----
// cd subcode q frame generator: track table lookup and mode 1 q frame pipeline
//
// Input channel req_*: one transfer per item. req_tuser selects the kind:
// a load writes one track slot (slot, track number, start sector, length,
// audio flag) and gives no result; a query carries a sector and gives one
// q frame on rsp_*. rsp_tuser is the hit flag; on a miss every data field is
// zero. Loads to slots past the table are dropped, length zero frees a slot.
// Throughput is one item per clock while the receiver takes results.
// A query's result passes through ten register stages: table compare,
// lowest slot select, track bcd, divide by 75, divide by 60, second split,
// bcd conversion and three crc stages of up to three table steps each.
// A load takes effect for every query that follows it.
// Reset empties the table at once through per-slot valid bits and drops any
// result in flight. When the receiver stalls, the whole pipeline holds and
// req_tready falls; nothing is lost or repeated.
module cd_subcode_q_generator (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // slot[4:0], track_num[11:5], start_sector[30:12], track_length[49:31],
   // audio_track[50], sector[69:51], zero pad
   input  logic [cdq_pkg::ReqDataWidth-1:0] req_tdata,
   // cmd[0]
   input  logic                              req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // control_adr[7:0], track_bcd[15:8], index_byte[16], rel_minute_bcd[24:17],
   // rel_second_bcd[32:25], rel_frame_bcd[40:33], abs_minute_bcd[48:41],
   // abs_second_bcd[56:49], abs_frame_bcd[64:57], q_crc[80:65], zero pad
   output logic [cdq_pkg::RspDataWidth-1:0] rsp_tdata,
   // hit[0]
   output logic                              rsp_tuser
);

   localparam int unsigned NumSlots = cdq_pkg::MaxTracks;
   localparam int unsigned QW       = cdq_pkg::QuotWidth;
   localparam int unsigned MW       = cdq_pkg::MinuteWidth;

   typedef struct packed {
      logic       hit;
      logic [7:0] ctl;
      logic [7:0] trk;
   } hdr_type;

   // input fields
   logic [cdq_pkg::SlotWidth-1:0] in_slot;
   logic [6:0]  in_track;
   logic [18:0] in_start;
   logic [18:0] in_length;
   logic        in_audio;
   logic [18:0] in_sector;
   logic        take;
   logic        adv;

   assign in_slot   = req_tdata[4:0];
   assign in_track  = req_tdata[11:5];
   assign in_start  = req_tdata[30:12];
   assign in_length = req_tdata[49:31];
   assign in_audio  = req_tdata[50];
   assign in_sector = req_tdata[69:51];

   // the pipeline moves as a whole whenever the output register can take a result
   assign adv        = !rsp_tvalid || rsp_tready;
   assign req_tready = adv;
   assign take       = req_tvalid && adv;

   // track table
   logic [NumSlots-1:0] slot_valid_ff;
   logic [6:0]          tab_track_ff  [NumSlots];
   logic [18:0]         tab_start_ff  [NumSlots];
   logic [18:0]         tab_length_ff [NumSlots];
   logic                tab_audio_ff  [NumSlots];
   logic                load_in;

   assign load_in = take && (cdq_pkg::cmd_type'(req_tuser) == cdq_pkg::CMD_LOAD) &&
                    (32'(in_slot) < NumSlots);

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_valid_ff <= '0;
      end else if (load_in) begin
         slot_valid_ff[in_slot] <= (in_length != '0);
      end
   end

   always_ff @(posedge clock) begin
      if (load_in) begin
         tab_track_ff[in_slot]  <= in_track;
         tab_start_ff[in_slot]  <= in_start;
         tab_length_ff[in_slot] <= in_length;
         tab_audio_ff[in_slot]  <= in_audio;
      end
   end

   // stage 0: compare the sector against every slot in parallel
   logic [NumSlots-1:0] match_in;
   logic [NumSlots-1:0] s0_match_ff;
   logic [18:0]         s0_sector_ff;
   logic                s0_valid_ff;

   always_comb begin
      for (int i = 0; i < NumSlots; i++) begin
         match_in[i] = slot_valid_ff[i] && (in_sector >= tab_start_ff[i]) &&
                       ({1'b0, in_sector} < ({1'b0, tab_start_ff[i]} +
                                             {1'b0, tab_length_ff[i]}));
      end
   end

   // stage 1: lowest matching slot, read while no load can slip in between
   logic [NumSlots-1:0] first_hot;
   logic [6:0]          sel_track;
   logic [18:0]         sel_start;
   logic                sel_audio;
   logic                s1_valid_ff;
   logic                s1_hit_ff;
   logic [6:0]          s1_track_ff;
   logic [18:0]         s1_start_ff;
   logic                s1_audio_ff;
   logic [18:0]         s1_sector_ff;
   logic [19:0]         s1_abs_ff;

   assign first_hot = s0_match_ff & (~s0_match_ff + NumSlots'(1));

   always_comb begin
      sel_track = '0;
      sel_start = '0;
      sel_audio = 1'b0;
      for (int i = 0; i < NumSlots; i++) begin
         if (first_hot[i]) begin
            sel_track |= tab_track_ff[i];
            sel_start |= tab_start_ff[i];
            sel_audio |= tab_audio_ff[i];
         end
      end
   end

   // stage 2: header bytes and relative position
   logic    s2_valid_ff;
   hdr_type s2_hdr_ff;
   logic [19:0] s2_rel_ff;
   logic [19:0] s2_abs_ff;

   // stage 3: crc over the first three bytes, quotient by 75
   logic [39:0] rel_p75;
   logic [39:0] abs_p75;
   logic        s3_valid_ff;
   hdr_type     s3_hdr_ff;
   logic [15:0] s3_crc_ff;
   logic [19:0] s3_rel_ff;
   logic [19:0] s3_abs_ff;
   logic [QW-1:0] s3_relq_ff;
   logic [QW-1:0] s3_absq_ff;

   assign rel_p75 = 40'(s2_rel_ff) * 40'(cdq_pkg::Div75Mult);
   assign abs_p75 = 40'(s2_abs_ff) * 40'(cdq_pkg::Div75Mult);

   // stage 4: frame remainder and minutes
   logic [32:0] rel_p60;
   logic [32:0] abs_p60;
   logic [19:0] rel_frame_in;
   logic [19:0] abs_frame_in;
   logic        s4_valid_ff;
   hdr_type     s4_hdr_ff;
   logic [15:0] s4_crc_ff;
   logic [6:0]  s4_relf_ff;
   logic [6:0]  s4_absf_ff;
   logic [QW-1:0] s4_relq_ff;
   logic [QW-1:0] s4_absq_ff;
   logic [MW-1:0] s4_relm_ff;
   logic [MW-1:0] s4_absm_ff;

   assign rel_p60      = 33'(s3_relq_ff) * 33'(cdq_pkg::Div60Mult);
   assign abs_p60      = 33'(s3_absq_ff) * 33'(cdq_pkg::Div60Mult);
   assign rel_frame_in = 20'(s3_rel_ff - 20'(20'(s3_relq_ff) * 20'(cdq_pkg::FramesPerSecond)));
   assign abs_frame_in = 20'(s3_abs_ff - 20'(20'(s3_absq_ff) * 20'(cdq_pkg::FramesPerSecond)));

   // stage 5: seconds
   logic [QW-1:0] rel_sec_in;
   logic [QW-1:0] abs_sec_in;
   logic          s5_valid_ff;
   hdr_type       s5_hdr_ff;
   logic [15:0]   s5_crc_ff;
   logic [6:0]    s5_relf_ff;
   logic [6:0]    s5_absf_ff;
   logic [5:0]    s5_rels_ff;
   logic [5:0]    s5_abss_ff;
   logic [MW-1:0] s5_relm_ff;
   logic [MW-1:0] s5_absm_ff;

   assign rel_sec_in = QW'(s4_relq_ff - QW'(QW'(s4_relm_ff) * QW'(cdq_pkg::SecondsPerMinute)));
   assign abs_sec_in = QW'(s4_absq_ff - QW'(QW'(s4_absm_ff) * QW'(cdq_pkg::SecondsPerMinute)));

   // stage 6: bcd of the six time fields
   logic        s6_valid_ff;
   hdr_type     s6_hdr_ff;
   logic [15:0] s6_crc_ff;
   logic [7:0]  s6_relm_ff, s6_rels_ff, s6_relf_ff;
   logic [7:0]  s6_absm_ff, s6_abss_ff, s6_absf_ff;

   // stage 7: crc over the relative time
   logic        s7_valid_ff;
   hdr_type     s7_hdr_ff;
   logic [15:0] s7_crc_ff;
   logic [7:0]  s7_relm_ff, s7_rels_ff, s7_relf_ff;
   logic [7:0]  s7_absm_ff, s7_abss_ff, s7_absf_ff;

   // stage 8: crc over pad, absolute minute and second
   logic        s8_valid_ff;
   hdr_type     s8_hdr_ff;
   logic [15:0] s8_crc_ff;
   logic [7:0]  s8_relm_ff, s8_rels_ff, s8_relf_ff;
   logic [7:0]  s8_absm_ff, s8_abss_ff, s8_absf_ff;

   // stage 9: output register, zeroed on a miss
   logic        out_valid_ff;
   logic        out_hit_ff;
   logic [7:0]  out_ctl_ff, out_trk_ff;
   logic        out_index_ff;
   logic [7:0]  out_relm_ff, out_rels_ff, out_relf_ff;
   logic [7:0]  out_absm_ff, out_abss_ff, out_absf_ff;
   logic [15:0] out_crc_ff;
   logic [15:0] crc_last_in;

   assign crc_last_in = ~cdq_pkg::crc_next(s8_crc_ff, s8_absf_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff  <= 1'b0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         s5_valid_ff  <= 1'b0;
         s6_valid_ff  <= 1'b0;
         s7_valid_ff  <= 1'b0;
         s8_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         s0_valid_ff  <= take && (cdq_pkg::cmd_type'(req_tuser) == cdq_pkg::CMD_QUERY);
         s1_valid_ff  <= s0_valid_ff;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         s4_valid_ff  <= s3_valid_ff;
         s5_valid_ff  <= s4_valid_ff;
         s6_valid_ff  <= s5_valid_ff;
         s7_valid_ff  <= s6_valid_ff;
         s8_valid_ff  <= s7_valid_ff;
         out_valid_ff <= s8_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s0_match_ff  <= match_in;
         s0_sector_ff <= in_sector;

         s1_hit_ff    <= (s0_match_ff != '0);
         s1_track_ff  <= sel_track;
         s1_start_ff  <= sel_start;
         s1_audio_ff  <= sel_audio;
         s1_sector_ff <= s0_sector_ff;
         s1_abs_ff    <= 20'(s0_sector_ff) + 20'(cdq_pkg::LeadIn);

         s2_hdr_ff.hit <= s1_hit_ff;
         s2_hdr_ff.ctl <= s1_audio_ff ? cdq_pkg::ControlAudio : cdq_pkg::ControlData;
         s2_hdr_ff.trk <= cdq_pkg::bcd8({1'b0, s1_track_ff});
         s2_rel_ff     <= 20'(s1_sector_ff - s1_start_ff);
         s2_abs_ff     <= s1_abs_ff;

         s3_hdr_ff  <= s2_hdr_ff;
         s3_crc_ff  <= cdq_pkg::crc_next(cdq_pkg::crc_next(cdq_pkg::crc_next(16'h0000,
                          s2_hdr_ff.ctl), s2_hdr_ff.trk), cdq_pkg::IndexOne);
         s3_rel_ff  <= s2_rel_ff;
         s3_abs_ff  <= s2_abs_ff;
         s3_relq_ff <= rel_p75[cdq_pkg::Div75Shift +: QW];
         s3_absq_ff <= abs_p75[cdq_pkg::Div75Shift +: QW];

         s4_hdr_ff  <= s3_hdr_ff;
         s4_crc_ff  <= s3_crc_ff;
         s4_relf_ff <= rel_frame_in[6:0];
         s4_absf_ff <= abs_frame_in[6:0];
         s4_relq_ff <= s3_relq_ff;
         s4_absq_ff <= s3_absq_ff;
         s4_relm_ff <= rel_p60[cdq_pkg::Div60Shift +: MW];
         s4_absm_ff <= abs_p60[cdq_pkg::Div60Shift +: MW];

         s5_hdr_ff  <= s4_hdr_ff;
         s5_crc_ff  <= s4_crc_ff;
         s5_relf_ff <= s4_relf_ff;
         s5_absf_ff <= s4_absf_ff;
         s5_rels_ff <= rel_sec_in[5:0];
         s5_abss_ff <= abs_sec_in[5:0];
         s5_relm_ff <= s4_relm_ff;
         s5_absm_ff <= s4_absm_ff;

         s6_hdr_ff  <= s5_hdr_ff;
         s6_crc_ff  <= s5_crc_ff;
         s6_relm_ff <= cdq_pkg::bcd8(s5_relm_ff);
         s6_rels_ff <= cdq_pkg::bcd8({2'b00, s5_rels_ff});
         s6_relf_ff <= cdq_pkg::bcd8({1'b0, s5_relf_ff});
         s6_absm_ff <= cdq_pkg::bcd8(s5_absm_ff);
         s6_abss_ff <= cdq_pkg::bcd8({2'b00, s5_abss_ff});
         s6_absf_ff <= cdq_pkg::bcd8({1'b0, s5_absf_ff});

         s7_hdr_ff  <= s6_hdr_ff;
         s7_crc_ff  <= cdq_pkg::crc_next(cdq_pkg::crc_next(cdq_pkg::crc_next(s6_crc_ff,
                          s6_relm_ff), s6_rels_ff), s6_relf_ff);
         s7_relm_ff <= s6_relm_ff;
         s7_rels_ff <= s6_rels_ff;
         s7_relf_ff <= s6_relf_ff;
         s7_absm_ff <= s6_absm_ff;
         s7_abss_ff <= s6_abss_ff;
         s7_absf_ff <= s6_absf_ff;

         s8_hdr_ff  <= s7_hdr_ff;
         s8_crc_ff  <= cdq_pkg::crc_next(cdq_pkg::crc_next(cdq_pkg::crc_next(s7_crc_ff,
                          cdq_pkg::PadByte), s7_absm_ff), s7_abss_ff);
         s8_relm_ff <= s7_relm_ff;
         s8_rels_ff <= s7_rels_ff;
         s8_relf_ff <= s7_relf_ff;
         s8_absm_ff <= s7_absm_ff;
         s8_abss_ff <= s7_abss_ff;
         s8_absf_ff <= s7_absf_ff;

         // a miss clears every field, crc included
         out_hit_ff   <= s8_hdr_ff.hit;
         out_ctl_ff   <= s8_hdr_ff.hit ? s8_hdr_ff.ctl : 8'h00;
         out_trk_ff   <= s8_hdr_ff.hit ? s8_hdr_ff.trk : 8'h00;
         out_index_ff <= s8_hdr_ff.hit;
         out_relm_ff  <= s8_hdr_ff.hit ? s8_relm_ff : 8'h00;
         out_rels_ff  <= s8_hdr_ff.hit ? s8_rels_ff : 8'h00;
         out_relf_ff  <= s8_hdr_ff.hit ? s8_relf_ff : 8'h00;
         out_absm_ff  <= s8_hdr_ff.hit ? s8_absm_ff : 8'h00;
         out_abss_ff  <= s8_hdr_ff.hit ? s8_abss_ff : 8'h00;
         out_absf_ff  <= s8_hdr_ff.hit ? s8_absf_ff : 8'h00;
         out_crc_ff   <= s8_hdr_ff.hit ? crc_last_in : 16'h0000;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_hit_ff;
   assign rsp_tdata  = {7'b0000000, out_crc_ff, out_absf_ff, out_abss_ff, out_absm_ff,
                        out_relf_ff, out_rels_ff, out_relm_ff, out_index_ff,
                        out_trk_ff, out_ctl_ff};

endmodule

// ----- rtl/cdq_checker.sv -----
// port level checks of the subcode q generator and their bind
module cdq_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_tready,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [cdq_pkg::RspDataWidth-1:0] rsp_tdata,
   input logic                              rsp_tuser
);

   // a stalled result holds its data
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

   // a miss carries an all zero frame
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata == '0)
      else $error("miss with nonzero data");

   // a hit has index one and a valid control byte
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[16] &&
         (rsp_tdata[7:0] == cdq_pkg::ControlAudio || rsp_tdata[7:0] == cdq_pkg::ControlData))
      else $error("hit with bad control or index");

   // an empty output stage always takes input
   assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled with empty output");

   // reset drops results in flight
   assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result after reset");

endmodule

bind cd_subcode_q_generator cdq_checker u_cdq_checker (.*);
